[rtl/eti_pkg.sv]
`timescale 1ns / 1ps

package eti_pkg;

  localparam int CoordWidth = 32;
  localparam int FracBits   = 28;
  localparam int CountWidth = 16;
  localparam int ProdWidth  = 2 * CoordWidth;
  localparam int WideWidth  = ProdWidth + 2;
  localparam int KindWidth  = 2;
  localparam int CfgIdxWidth = 2;

  localparam logic [WideWidth-1:0] EscapeBound = WideWidth'(1) << (2 * FracBits + 2);

  typedef enum logic [KindWidth-1:0] {
    KIND_MANDELBROT   = 2'd0,
    KIND_JULIA        = 2'd1,
    KIND_BURNING_SHIP = 2'd2,
    KIND_TRICORN      = 2'd3
  } eti_kind_e;

  typedef enum logic [CfgIdxWidth-1:0] {
    CFG_FRACTAL_KIND   = 2'd0,
    CFG_MAX_ITERATIONS = 2'd1,
    CFG_JULIA_CONST_RE = 2'd2,
    CFG_JULIA_CONST_IM = 2'd3
  } eti_cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_TEST,
    ST_DONE
  } eti_state_e;

  typedef struct packed {
    logic signed [CoordWidth-1:0] point_re;
    logic signed [CoordWidth-1:0] point_im;
  } eti_in_t;

  typedef struct packed {
    logic signed [CoordWidth-1:0] echo_re;
    logic signed [CoordWidth-1:0] echo_im;
    logic [CountWidth-1:0]        iterations;
    logic                         escaped;
  } eti_out_t;

  typedef struct packed {
    logic load;
    logic capture;
    logic advance;
    logic flag_escape;
  } eti_cmd_t;

  typedef struct packed {
    logic limit_hit;
    logic escape;
  } eti_stat_t;

  function automatic logic signed [CoordWidth-1:0] sat_coord(
    input logic signed [WideWidth-1:0] v
  );
    logic signed [CoordWidth-1:0] r;
    if (&v[WideWidth-1:CoordWidth-1] || ~|v[WideWidth-1:CoordWidth-1]) begin
      r = v[CoordWidth-1:0];
    end else if (v[WideWidth-1]) begin
      r = {1'b1, {(CoordWidth-1){1'b0}}};
    end else begin
      r = {1'b0, {(CoordWidth-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

[rtl/eti_ctrl.sv]
`timescale 1ns / 1ps

module eti_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  input  eti_pkg::eti_stat_t stat_i,
  output eti_pkg::eti_cmd_t  cmd_o,
  output logic              busy,
  output logic              result_valid_o
);
  import eti_pkg::*;

  eti_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start) state_d = ST_CHECK;
      end
      ST_CHECK: begin
        state_d = stat_i.limit_hit ? ST_DONE : ST_TEST;
      end
      ST_TEST: begin
        state_d = stat_i.escape ? ST_DONE : ST_CHECK;
      end
      ST_DONE: begin
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o          = '0;
    busy           = 1'b1;
    result_valid_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        busy       = 1'b0;
        cmd_o.load = start;
      end
      ST_CHECK: begin
        cmd_o.capture = ~stat_i.limit_hit;
      end
      ST_TEST: begin
        cmd_o.advance     = ~stat_i.escape;
        cmd_o.flag_escape = stat_i.escape;
      end
      ST_DONE: begin
        result_valid_o = 1'b1;
      end
      default: busy = 1'b0;
    endcase
  end

endmodule

[rtl/eti_dpath.sv]
`timescale 1ns / 1ps

module eti_dpath (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  eti_pkg::eti_cmd_t                      cmd_i,
  input  eti_pkg::eti_in_t                       in_i,
  input  eti_pkg::eti_kind_e                     kind_i,
  input  logic [eti_pkg::CountWidth-1:0]         max_iter_i,
  input  logic signed [eti_pkg::CoordWidth-1:0]  julia_re_i,
  input  logic signed [eti_pkg::CoordWidth-1:0]  julia_im_i,
  output eti_pkg::eti_stat_t                     stat_o,
  output eti_pkg::eti_out_t                      out_o
);
  import eti_pkg::*;

  logic signed [CoordWidth-1:0] zr_q, zi_q, cr_q, ci_q, echo_re_q, echo_im_q;
  logic signed [ProdWidth-1:0]  sr_q, si_q, p_q;
  logic [CountWidth-1:0]        cnt_q;
  logic                         esc_q;

  logic [WideWidth-1:0]         mag_sum;
  logic signed [WideWidth-1:0]  diff_w, cross_w, re_w, im_w;

  assign mag_sum = WideWidth'(unsigned'(sr_q)) + WideWidth'(unsigned'(si_q));
  assign diff_w  = WideWidth'(sr_q) - WideWidth'(si_q);

  always_comb begin
    unique case (kind_i)
      KIND_BURNING_SHIP: cross_w = p_q[ProdWidth-1] ? WideWidth'(p_q) : -WideWidth'(p_q);
      KIND_TRICORN:      cross_w = -WideWidth'(p_q);
      default:           cross_w = WideWidth'(p_q);
    endcase
  end

  assign re_w = (diff_w >>> FracBits) + WideWidth'(cr_q);
  assign im_w = (cross_w >>> (FracBits - 1)) + WideWidth'(ci_q);

  assign stat_o.limit_hit = cnt_q >= max_iter_i;
  assign stat_o.escape    = mag_sum > EscapeBound;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      esc_q <= 1'b0;
    end else if (cmd_i.load) begin
      cnt_q <= '0;
      esc_q <= 1'b0;
    end else begin
      if (cmd_i.advance)     cnt_q <= cnt_q + CountWidth'(1);
      if (cmd_i.flag_escape) esc_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      echo_re_q <= in_i.point_re;
      echo_im_q <= in_i.point_im;
      if (kind_i == KIND_JULIA) begin
        zr_q <= in_i.point_re;
        zi_q <= in_i.point_im;
        cr_q <= julia_re_i;
        ci_q <= julia_im_i;
      end else begin
        zr_q <= '0;
        zi_q <= '0;
        cr_q <= in_i.point_re;
        ci_q <= in_i.point_im;
      end
    end else if (cmd_i.advance) begin
      zr_q <= sat_coord(re_w);
      zi_q <= sat_coord(im_w);
    end
    if (cmd_i.capture) begin
      sr_q <= ProdWidth'(zr_q) * ProdWidth'(zr_q);
      si_q <= ProdWidth'(zi_q) * ProdWidth'(zi_q);
      p_q  <= ProdWidth'(zr_q) * ProdWidth'(zi_q);
    end
  end

  assign out_o.echo_re    = echo_re_q;
  assign out_o.echo_im    = echo_im_q;
  assign out_o.iterations = cnt_q;
  assign out_o.escaped    = esc_q;

endmodule

[rtl/escape_time_fractal_iteration.sv]
`timescale 1ns / 1ps

// Escape-time iteration for Mandelbrot, Julia, Burning Ship and Tricorn sets in
// signed Q4.28. A point is taken when start is high and busy is low; the result
// (point echo, step count, escape flag) appears for exactly one cycle with
// result_valid_o and must be captured then, as the receiver cannot stall it.
// Each step passes through the controller states CHECK, which ends the point at
// the limit or else registers the three 32x32 multiplier products, and TEST,
// which ends it on escape or else updates z. The user must write configuration
// through cfg_we_i only while the block is idle; the block does not enforce it.
module escape_time_fractal_iteration (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  eti_pkg::eti_in_t                    in_i,
  output logic                                result_valid_o,
  output eti_pkg::eti_out_t                   out_o,
  input  logic                                cfg_we_i,
  input  logic [eti_pkg::CfgIdxWidth-1:0]     cfg_index_i,
  input  logic [eti_pkg::CoordWidth-1:0]      cfg_wdata_i
);
  import eti_pkg::*;

  eti_kind_e                    kind_q;
  logic [CountWidth-1:0]        max_iter_q;
  logic signed [CoordWidth-1:0] julia_re_q, julia_im_q;
  eti_cmd_t                     cmd;
  eti_stat_t                    stat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q     <= KIND_MANDELBROT;
      max_iter_q <= CountWidth'(256);
      julia_re_q <= '0;
      julia_im_q <= '0;
    end else if (cfg_we_i) begin
      unique case (eti_cfg_idx_e'(cfg_index_i))
        CFG_FRACTAL_KIND:   kind_q     <= eti_kind_e'(cfg_wdata_i[KindWidth-1:0]);
        CFG_MAX_ITERATIONS: max_iter_q <= cfg_wdata_i[CountWidth-1:0];
        CFG_JULIA_CONST_RE: julia_re_q <= cfg_wdata_i;
        CFG_JULIA_CONST_IM: julia_im_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  eti_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .stat_i         (stat),
    .cmd_o          (cmd),
    .busy           (busy),
    .result_valid_o (result_valid_o)
  );

  eti_dpath u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .in_i       (in_i),
    .kind_i     (kind_q),
    .max_iter_i (max_iter_q),
    .julia_re_i (julia_re_q),
    .julia_im_i (julia_im_q),
    .stat_o     (stat),
    .out_o      (out_o)
  );

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("accepted point did not raise busy");

  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe longer than one cycle");

  a_bounded_at_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !out_o.escaped |-> out_o.iterations == max_iter_q)
    else $error("bounded point did not reach the limit");

  a_count_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> out_o.iterations <= max_iter_q)
    else $error("step count beyond the limit");

endmodule

[tb/tb_escape_time_fractal_iteration.sv]
`timescale 1ns / 1ps

module tb_escape_time_fractal_iteration;
  import eti_pkg::*;

  localparam int unsigned CycleLimit = 4_000_000;
  localparam int NumPhases = 8;
  localparam int PhaseItems = 100;

  localparam logic [31:0] CoordMax = 32'h7fff_ffff;
  localparam logic [31:0] CoordMin = 32'h8000_0000;
  localparam logic [31:0] One      = 32'h1000_0000;
  localparam logic [31:0] NegOne   = 32'hf000_0000;
  localparam logic [31:0] Two      = 32'h2000_0000;
  localparam logic [31:0] NegTwo   = 32'he000_0000;
  localparam logic [31:0] Quarter  = 32'h0400_0000;

  typedef struct packed {
    eti_kind_e   kind;
    logic [15:0] limit;
    logic [31:0] c_re;
    logic [31:0] c_im;
    logic [31:0] p_re;
    logic [31:0] p_im;
    logic        known;
    logic [15:0] iters;
    logic        esc;
  } probe_t;

  localparam int NumProbes = 26;
  localparam probe_t Probes [NumProbes] = '{
    '{KIND_MANDELBROT,   16'd256,   32'h0,    32'h0,    32'h0,        32'h0,        1'b1,
      16'd256,   1'b0},
    '{KIND_MANDELBROT,   16'd256,   32'h0,    32'h0,    CoordMax,     CoordMax,     1'b1,
      16'd1,     1'b1},
    '{KIND_MANDELBROT,   16'd256,   32'h0,    32'h0,    CoordMin,     CoordMin,     1'b1,
      16'd1,     1'b1},
    '{KIND_MANDELBROT,   16'd256,   32'h0,    32'h0,    CoordMin,     CoordMax,     1'b1,
      16'd1,     1'b1},
    '{KIND_MANDELBROT,   16'd256,   32'h0,    32'h0,    CoordMax,     CoordMin,     1'b1,
      16'd1,     1'b1},
    '{KIND_MANDELBROT,   16'd256,   32'h0,    32'h0,    NegTwo,       32'h0,        1'b1,
      16'd256,   1'b0},
    '{KIND_MANDELBROT,   16'd256,   32'h0,    32'h0,    NegOne,       32'h0,        1'b1,
      16'd256,   1'b0},
    '{KIND_MANDELBROT,   16'd256,   32'h0,    32'h0,    32'h0,        One,          1'b1,
      16'd256,   1'b0},
    '{KIND_MANDELBROT,   16'd256,   32'h0,    32'h0,    Quarter,      32'h0,        1'b0,
      16'd0,     1'b0},
    '{KIND_MANDELBROT,   16'd256,   32'h0,    32'h0,    32'h0410_0000, 32'h0,       1'b0,
      16'd0,     1'b0},
    '{KIND_MANDELBROT,   16'd0,     32'h0,    32'h0,    CoordMax,     CoordMax,     1'b1,
      16'd0,     1'b0},
    '{KIND_MANDELBROT,   16'd1,     32'h0,    32'h0,    CoordMax,     CoordMax,     1'b1,
      16'd1,     1'b0},
    '{KIND_JULIA,        16'd256,   32'h0,    32'h0,    CoordMax,     CoordMax,     1'b1,
      16'd0,     1'b1},
    '{KIND_JULIA,        16'd256,   CoordMin, CoordMax, 32'h0,        32'h0,        1'b1,
      16'd1,     1'b1},
    '{KIND_JULIA,        16'd256,   NegTwo,   32'h0,    Two,          32'h0,        1'b1,
      16'd256,   1'b0},
    '{KIND_JULIA,        16'd256,   CoordMax, CoordMax, NegTwo,       32'h0,        1'b0,
      16'd0,     1'b0},
    '{KIND_JULIA,        16'd256,   CoordMin, CoordMin, 32'h0,        Two,          1'b0,
      16'd0,     1'b0},
    '{KIND_JULIA,        16'd0,     32'hf500_0000, 32'h0200_0000, Quarter, 32'h0,  1'b1,
      16'd0,     1'b0},
    '{KIND_JULIA,        16'd256,   32'hf300_0000, 32'h02e0_0000, 32'h0100_0000,
      32'hff00_0000, 1'b0, 16'd0, 1'b0},
    '{KIND_BURNING_SHIP, 16'd256,   32'h0,    32'h0,    CoordMax,     CoordMax,     1'b1,
      16'd1,     1'b1},
    '{KIND_BURNING_SHIP, 16'd256,   32'h0,    32'h0,    32'he400_0000, 32'hff80_0000, 1'b0,
      16'd0,     1'b0},
    '{KIND_BURNING_SHIP, 16'd256,   32'h0,    32'h0,    32'h0800_0000, 32'hf800_0000, 1'b0,
      16'd0,     1'b0},
    '{KIND_TRICORN,      16'd256,   32'h0,    32'h0,    CoordMin,     CoordMin,     1'b1,
      16'd1,     1'b1},
    '{KIND_TRICORN,      16'd256,   32'h0,    32'h0,    NegOne,       32'h0,        1'b0,
      16'd0,     1'b0},
    '{KIND_TRICORN,      16'd256,   32'h0,    32'h0,    32'h04cc_cccc, 32'h0800_0000, 1'b0,
      16'd0,     1'b0},
    '{KIND_MANDELBROT,   16'd65535, 32'h0,    32'h0,    32'h0,        32'h0,        1'b1,
      16'd65535, 1'b0}
  };

  logic                   clk_i;
  logic                   rst_ni;
  logic                   start;
  logic                   busy;
  eti_in_t                in_i;
  logic                   result_valid_o;
  eti_out_t               out_o;
  logic                   cfg_we_i;
  logic [CfgIdxWidth-1:0] cfg_index_i;
  logic [CoordWidth-1:0]  cfg_wdata_i;

  eti_kind_e          kind_now;
  logic [15:0]        limit_now;
  logic signed [31:0] julia_re_now;
  logic signed [31:0] julia_im_now;

  eti_out_t    escape_due [$];
  int          bad_fields;
  int unsigned cycles;

  escape_time_fractal_iteration i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .in_i          (in_i),
    .result_valid_o(result_valid_o),
    .out_o         (out_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  function automatic logic signed [31:0] clamp_coord(longint v);
    if (v > 64'sh7fff_ffff) begin
      return CoordMax;
    end else if (v < -64'sh8000_0000) begin
      return CoordMin;
    end
    return v[31:0];
  endfunction

  function automatic eti_out_t escape_count(eti_in_t pt);
    logic signed [31:0] zr, zi, cr, ci;
    longint             sqr, sqi, prod, twist;
    logic [65:0]        mag2;
    int unsigned        n;
    eti_out_t           r;
    if (kind_now == KIND_JULIA) begin
      zr = pt.point_re;
      zi = pt.point_im;
      cr = julia_re_now;
      ci = julia_im_now;
    end else begin
      zr = '0;
      zi = '0;
      cr = pt.point_re;
      ci = pt.point_im;
    end
    n = 0;
    r.escaped = 1'b0;
    while (n < limit_now) begin
      sqr  = longint'(zr) * longint'(zr);
      sqi  = longint'(zi) * longint'(zi);
      mag2 = 66'(sqr) + 66'(sqi);
      if (mag2 > (66'd1 << (2 * FracBits + 2))) begin
        r.escaped = 1'b1;
        break;
      end
      prod = longint'(zr) * longint'(zi);
      case (kind_now)
        KIND_BURNING_SHIP: twist = (prod < 0) ? prod : -prod;
        KIND_TRICORN:      twist = -prod;
        default:           twist = prod;
      endcase
      zr = clamp_coord(((sqr - sqi) >>> FracBits) + longint'(cr));
      zi = clamp_coord((twist >>> (FracBits - 1)) + longint'(ci));
      n++;
    end
    r.echo_re    = pt.point_re;
    r.echo_im    = pt.point_im;
    r.iterations = n[15:0];
    return r;
  endfunction

  function automatic logic [31:0] pick_coord();
    logic [31:0] v;
    case ($urandom_range(0, 9))
      0:       v = $urandom;
      1:       v = $urandom_range(0, 1) ? CoordMax : CoordMin;
      default: v = int'($urandom_range(0, 1342177279)) - 671088640;
    endcase
    return v;
  endfunction

  task automatic write_reg(eti_cfg_idx_e idx, logic [31:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
  endtask

  task automatic apply_config(eti_kind_e k, logic [15:0] lim, logic [31:0] cre,
                              logic [31:0] cim);
    logic [31:0] junk;
    junk = $urandom;
    write_reg(CFG_FRACTAL_KIND, {junk[31:KindWidth], k});
    write_reg(CFG_MAX_ITERATIONS, {junk[15:0], lim});
    write_reg(CFG_JULIA_CONST_RE, cre);
    write_reg(CFG_JULIA_CONST_IM, cim);
    cfg_we_i     <= 1'b0;
    kind_now     = k;
    limit_now    = lim;
    julia_re_now = cre;
    julia_im_now = cim;
  endtask

  task automatic quiesce();
    start <= 1'b0;
    while (escape_due.size() != 0) @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  task automatic idle_burst();
    start <= 1'b0;
    repeat ($urandom_range(1, 14)) @(posedge clk_i);
  endtask

  task automatic send_point(eti_in_t pt, logic known, logic [15:0] iters, logic esc);
    eti_out_t r;
    start <= 1'b1;
    in_i  <= pt;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    if (known) begin
      r.echo_re    = pt.point_re;
      r.echo_im    = pt.point_im;
      r.iterations = iters;
      r.escaped    = esc;
    end else begin
      r = escape_count(pt);
    end
    escape_due = {escape_due, r};
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %h, got %h", $time, name, want, got);
      bad_fields++;
    end
  endtask

  always @(posedge clk_i) begin
    eti_out_t want;
    if (rst_ni && result_valid_o) begin
      if (escape_due.size() == 0) begin
        $display("%0t: result with none expected, got %h", $time, out_o);
        bad_fields++;
      end else begin
        want = escape_due.pop_front();
        check_field("echo_re", want.echo_re, out_o.echo_re);
        check_field("echo_im", want.echo_im, out_o.echo_im);
        check_field("iterations", 32'(want.iterations), 32'(out_o.iterations));
        check_field("escaped", 32'(want.escaped), 32'(out_o.escaped));
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    eti_in_t     pt;
    eti_kind_e   k;
    logic [15:0] lim;
    logic [31:0] cre, cim;
    bit          calm;
    bad_fields   = 0;
    cycles       = 0;
    kind_now     = KIND_MANDELBROT;
    limit_now    = 16'd256;
    julia_re_now = '0;
    julia_im_now = '0;
    rst_ni       = 1'b0;
    start        = 1'b0;
    in_i         = '0;
    cfg_we_i     = 1'b0;
    cfg_index_i  = CFG_FRACTAL_KIND;
    cfg_wdata_i  = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (Probes[i]) begin
      if (Probes[i].kind != kind_now || Probes[i].limit != limit_now ||
          Probes[i].c_re != julia_re_now || Probes[i].c_im != julia_im_now) begin
        quiesce();
        apply_config(Probes[i].kind, Probes[i].limit, Probes[i].c_re, Probes[i].c_im);
      end
      pt.point_re = Probes[i].p_re;
      pt.point_im = Probes[i].p_im;
      send_point(pt, Probes[i].known, Probes[i].iters, Probes[i].esc);
      if ($urandom_range(0, 2) == 0) idle_burst();
    end

    for (int p = 0; p < NumPhases; p++) begin
      k = eti_kind_e'(p % 4);
      case ($urandom_range(0, 4))
        0:       lim = 16'($urandom_range(0, 3));
        1:       lim = 16'($urandom_range(4, 40));
        2:       lim = 16'($urandom_range(41, 150));
        3:       lim = 16'd256;
        default: lim = 16'($urandom_range(257, 400));
      endcase
      if ($urandom_range(0, 3) == 0) begin
        cre = $urandom;
        cim = $urandom;
      end else begin
        cre = int'($urandom_range(0, 536870911)) - 268435456;
        cim = int'($urandom_range(0, 536870911)) - 268435456;
      end
      quiesce();
      apply_config(k, lim, cre, cim);
      calm = (p == NumPhases - 1) || ($urandom_range(0, 3) == 0);
      for (int n = 0; n < PhaseItems; n++) begin
        pt.point_re = pick_coord();
        pt.point_im = pick_coord();
        send_point(pt, 1'b0, '0, 1'b0);
        if (!calm && $urandom_range(0, 2) == 0) idle_burst();
      end
    end

    quiesce();
    repeat (8) @(posedge clk_i);
    if (bad_fields == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

[escape_time_fractal_iteration.f]
rtl/eti_pkg.sv
rtl/eti_ctrl.sv
rtl/eti_dpath.sv
rtl/escape_time_fractal_iteration.sv
tb/tb_escape_time_fractal_iteration.sv
